### sv/wmds_pkg.sv
// Package with the strip slot codes and result kinds shared by the window difference blocks.
`default_nettype none

package wmds_pkg;

    localparam int unsigned NUM_SLOTS = 8;

    // One slot per possible strip, in the order the strips are delivered.
    typedef enum logic [2:0] {
        SLOT_REM_TOP    = 3'd0,
        SLOT_REM_BOTTOM = 3'd1,
        SLOT_REM_LEFT   = 3'd2,
        SLOT_REM_RIGHT  = 3'd3,
        SLOT_ADD_TOP    = 3'd4,
        SLOT_ADD_BOTTOM = 3'd5,
        SLOT_ADD_LEFT   = 3'd6,
        SLOT_ADD_RIGHT  = 3'd7
    } t_slot;

    typedef logic [NUM_SLOTS-1:0] t_slot_mask;

    localparam logic KIND_REMOVE = 1'b0;
    localparam logic KIND_ADD    = 1'b1;

endpackage

`default_nettype wire

### sv/wmds_win_if.sv
// Interface that carries one new window request with its valid/ready handshake.
`default_nettype none

interface wmds_win_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] new_left;
    logic signed [COORD_BITS-1:0] new_top;
    logic        [COORD_BITS-2:0] new_width;
    logic        [COORD_BITS-2:0] new_height;

    modport source (
        output valid, new_left, new_top, new_width, new_height,
        input  ready
    );

    modport sink (
        input  valid, new_left, new_top, new_width, new_height,
        output ready
    );
endinterface

`default_nettype wire

### sv/wmds_strip_if.sv
// Interface that carries one strip request with its valid/ready handshake.
`default_nettype none

interface wmds_strip_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic                         strip_kind;
    logic signed [COORD_BITS-1:0] strip_left;
    logic signed [COORD_BITS-1:0] strip_top;
    logic        [COORD_BITS-2:0] strip_width;
    logic        [COORD_BITS-2:0] strip_height;
    logic                         strip_last;

    modport source (
        output valid, strip_kind, strip_left, strip_top, strip_width, strip_height,
               strip_last,
        input  ready
    );

    modport sink (
        input  valid, strip_kind, strip_left, strip_top, strip_width, strip_height,
               strip_last,
        output ready
    );
endinterface

`default_nettype wire

### sv/wmds_front.sv
// Front end: accepts new windows, holds the current window and classifies the move into strips.
`default_nettype none

module wmds_front #(
    parameter int COORD_BITS = 16,
    parameter int JOB_W      = 10 * (COORD_BITS + 1) + 9
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    wmds_win_if.sink              i_win,
    input  wire logic             i_full,
    output logic                  o_push,
    output logic [JOB_W-1:0]      o_job
);

    localparam int EW = COORD_BITS + 1;

    typedef struct packed {
        logic signed [EW-1:0]  ol;
        logic signed [EW-1:0]  ot;
        logic signed [EW-1:0]  nl;
        logic signed [EW-1:0]  nt;
        logic signed [EW-1:0]  ox2;
        logic signed [EW-1:0]  oy2;
        logic signed [EW-1:0]  nx2;
        logic signed [EW-1:0]  ny2;
        logic signed [EW-1:0]  rs;
        logic signed [EW-1:0]  re;
        logic                  overlap;
        wmds_pkg::t_slot_mask  mask;
    } t_job;

    logic signed [COORD_BITS-1:0] r_left;
    logic signed [COORD_BITS-1:0] r_top;
    logic        [COORD_BITS-2:0] r_width;
    logic        [COORD_BITS-2:0] r_height;

    logic signed [EW-1:0] ow;
    logic signed [EW-1:0] oh;
    logic signed [EW-1:0] nw;
    logic signed [EW-1:0] nh;
    logic signed [EW-1:0] max_l;
    logic signed [EW-1:0] min_r;
    logic                 old_full;
    logic                 new_full;
    logic                 accept;
    t_job                 job;

    assign i_win.ready = !i_full;
    assign accept      = i_win.valid && !i_full;

    always_comb begin
        job.ol  = {r_left[COORD_BITS-1], r_left};
        job.ot  = {r_top[COORD_BITS-1], r_top};
        job.nl  = {i_win.new_left[COORD_BITS-1], i_win.new_left};
        job.nt  = {i_win.new_top[COORD_BITS-1], i_win.new_top};
        ow      = {2'b00, r_width};
        oh      = {2'b00, r_height};
        nw      = {2'b00, i_win.new_width};
        nh      = {2'b00, i_win.new_height};
        job.ox2 = job.ol + ow;
        job.oy2 = job.ot + oh;
        job.nx2 = job.nl + nw;
        job.ny2 = job.nt + nh;
        job.rs  = (job.ot > job.nt) ? job.ot : job.nt;
        job.re  = (job.oy2 < job.ny2) ? job.oy2 : job.ny2;
        max_l   = (job.ol > job.nl) ? job.ol : job.nl;
        min_r   = (job.ox2 < job.nx2) ? job.ox2 : job.nx2;

        old_full    = (r_width != '0) && (r_height != '0);
        new_full    = (i_win.new_width != '0) && (i_win.new_height != '0);
        job.overlap = old_full && new_full && (max_l < min_r) && (job.rs < job.re);

        job.mask = '0;
        if (job.overlap) begin
            job.mask[wmds_pkg::SLOT_REM_TOP]    = job.ot < job.nt;
            job.mask[wmds_pkg::SLOT_REM_BOTTOM] = job.ny2 < job.oy2;
            job.mask[wmds_pkg::SLOT_REM_LEFT]   = job.ol < job.nl;
            job.mask[wmds_pkg::SLOT_REM_RIGHT]  = job.nx2 < job.ox2;
            job.mask[wmds_pkg::SLOT_ADD_TOP]    = job.nt < job.ot;
            job.mask[wmds_pkg::SLOT_ADD_BOTTOM] = job.oy2 < job.ny2;
            job.mask[wmds_pkg::SLOT_ADD_LEFT]   = job.nl < job.ol;
            job.mask[wmds_pkg::SLOT_ADD_RIGHT]  = job.ox2 < job.nx2;
        end else begin
            job.mask[wmds_pkg::SLOT_REM_TOP] = old_full;
            job.mask[wmds_pkg::SLOT_ADD_TOP] = new_full;
        end
    end

    // A move that produces no strip never enters the queue.
    assign o_push = accept && (job.mask != '0);
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_top    <= '0;
            r_width  <= '0;
            r_height <= '0;
        end else if (accept) begin
            r_left   <= i_win.new_left;
            r_top    <= i_win.new_top;
            r_width  <= i_win.new_width;
            r_height <= i_win.new_height;
        end
    end

endmodule

`default_nettype wire

### sv/wmds_queue.sv
// Small FIFO that decouples the classifying front end from the strip generator.
`default_nettype none

module wmds_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output logic      [DATA_W-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;
    logic              push_ok;
    logic              pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### sv/wmds_back.sv
// Back end: walks the slot mask of the queued move and issues one strip per cycle while the receiver is ready.
`default_nettype none

module wmds_back #(
    parameter int COORD_BITS = 16,
    parameter int JOB_W      = 10 * (COORD_BITS + 1) + 9
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [JOB_W-1:0] i_job,
    output logic                  o_pop,
    wmds_strip_if.source          o_strip
);

    localparam int EW = COORD_BITS + 1;

    typedef struct packed {
        logic signed [EW-1:0]  ol;
        logic signed [EW-1:0]  ot;
        logic signed [EW-1:0]  nl;
        logic signed [EW-1:0]  nt;
        logic signed [EW-1:0]  ox2;
        logic signed [EW-1:0]  oy2;
        logic signed [EW-1:0]  nx2;
        logic signed [EW-1:0]  ny2;
        logic signed [EW-1:0]  rs;
        logic signed [EW-1:0]  re;
        logic                  overlap;
        wmds_pkg::t_slot_mask  mask;
    } t_job;

    t_job                 job;
    wmds_pkg::t_slot_mask r_done;
    wmds_pkg::t_slot_mask rem;
    wmds_pkg::t_slot_mask pick;
    wmds_pkg::t_slot      slot;
    logic                 last;
    logic                 advance;

    logic                 kind;
    logic signed [EW-1:0] s_l;
    logic signed [EW-1:0] s_t;
    logic signed [EW-1:0] w_a;
    logic signed [EW-1:0] w_b;
    logic signed [EW-1:0] h_a;
    logic signed [EW-1:0] h_b;
    logic signed [EW-1:0] w_d;
    logic signed [EW-1:0] h_d;

    logic                         r_out_valid;
    logic                         r_kind;
    logic signed [COORD_BITS-1:0] r_left;
    logic signed [COORD_BITS-1:0] r_top;
    logic        [COORD_BITS-2:0] r_width;
    logic        [COORD_BITS-2:0] r_height;
    logic                         r_last;

    assign job = i_job;
    assign rem = job.mask & ~r_done;

    always_comb begin
        slot = wmds_pkg::SLOT_REM_TOP;
        for (int i = wmds_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (rem[i]) begin
                slot = wmds_pkg::t_slot'(3'(i));
            end
        end
    end

    assign pick    = wmds_pkg::t_slot_mask'(1) << slot;
    assign last    = (rem & ~pick) == '0;
    assign advance = i_valid && (!r_out_valid || o_strip.ready);
    assign o_pop   = advance && last;

    always_comb begin
        kind = wmds_pkg::KIND_REMOVE;
        s_l  = job.ol;
        s_t  = job.rs;
        w_a  = job.ox2;
        w_b  = job.ol;
        h_a  = job.re;
        h_b  = job.rs;
        case (slot)
            wmds_pkg::SLOT_REM_TOP: begin
                s_t = job.ot;
                h_a = job.overlap ? job.nt : job.oy2;
                h_b = job.ot;
            end
            wmds_pkg::SLOT_REM_BOTTOM: begin
                s_t = job.ny2;
                h_a = job.oy2;
                h_b = job.ny2;
            end
            wmds_pkg::SLOT_REM_LEFT: begin
                w_a = job.nl;
            end
            wmds_pkg::SLOT_REM_RIGHT: begin
                s_l = job.nx2;
                w_b = job.nx2;
            end
            wmds_pkg::SLOT_ADD_TOP: begin
                kind = wmds_pkg::KIND_ADD;
                s_l  = job.nl;
                s_t  = job.nt;
                w_a  = job.nx2;
                w_b  = job.nl;
                h_a  = job.overlap ? job.ot : job.ny2;
                h_b  = job.nt;
            end
            wmds_pkg::SLOT_ADD_BOTTOM: begin
                kind = wmds_pkg::KIND_ADD;
                s_l  = job.nl;
                s_t  = job.oy2;
                w_a  = job.nx2;
                w_b  = job.nl;
                h_a  = job.ny2;
                h_b  = job.oy2;
            end
            wmds_pkg::SLOT_ADD_LEFT: begin
                kind = wmds_pkg::KIND_ADD;
                s_l  = job.nl;
                w_a  = job.ol;
                w_b  = job.nl;
            end
            wmds_pkg::SLOT_ADD_RIGHT: begin
                kind = wmds_pkg::KIND_ADD;
                s_l  = job.ox2;
                w_a  = job.nx2;
                w_b  = job.ox2;
            end
            default: begin
                kind = wmds_pkg::KIND_REMOVE;
            end
        endcase
        w_d = w_a - w_b;
        h_d = h_a - h_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_done      <= '0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_done      <= last ? '0 : (r_done | pick);
        end else if (o_strip.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kind   <= kind;
            r_left   <= s_l[COORD_BITS-1:0];
            r_top    <= s_t[COORD_BITS-1:0];
            r_width  <= w_d[COORD_BITS-2:0];
            r_height <= h_d[COORD_BITS-2:0];
            r_last   <= last;
        end
    end

    assign o_strip.valid        = r_out_valid;
    assign o_strip.strip_kind   = r_kind;
    assign o_strip.strip_left   = r_left;
    assign o_strip.strip_top    = r_top;
    assign o_strip.strip_width  = r_width;
    assign o_strip.strip_height = r_height;
    assign o_strip.strip_last   = r_last;

    // Every queued move still has at least one strip to issue.
    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (rem != '0))
        else $error("queued move has no strip left");

    // The issued slots never leave the mask of the current move.
    a_done_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((r_done & ~job.mask) == '0))
        else $error("issued slot outside move mask");

    // Without a queued move no slot may be marked as issued.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |-> (r_done == '0))
        else $error("stale issued slots while queue is empty");

    // A strip leaves the output register with a nonzero size.
    a_strip_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_width != '0 && r_height != '0))
        else $error("empty strip issued");

endmodule

`default_nettype wire

### sv/window_move_difference_strips_core.sv
// Top level of the window move difference strip generator.
//
// A request on i_win names a new cell window (left, top, width, height). The
// block compares it with the stored window and returns the cells that leave
// and enter as rectangular strips on o_strip: removals first (top, bottom,
// left, right), then additions in the same order, with strip_last set on the
// final strip of the move. Disjoint windows give the whole old window and the
// whole new one; an identical or empty-to-empty move gives no strip.
// An accepted window that gives strips is written into the queue; the strip
// generator then registers the strips of the queued move one by one in the
// output register and pops the move with its last strip. A new window is taken
// every cycle while the queue between classifier and generator has room.
// When the receiver stalls, the strip stays in the output register and the
// queue fills; i_win.ready drops only when the queue is full.
// Reset sets the stored window to an empty window at the origin and empties
// the queue and the output register.
`default_nettype none

module window_move_difference_strips_core #(
    parameter int COORD_BITS  = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    wmds_win_if.sink     i_win,
    wmds_strip_if.source o_strip
);

    localparam int JOB_W = 10 * (COORD_BITS + 1) + wmds_pkg::NUM_SLOTS + 1;

    logic             push;
    logic             full;
    logic             pop;
    logic             q_valid;
    logic [JOB_W-1:0] push_job;
    logic [JOB_W-1:0] head_job;

    wmds_front #(
        .COORD_BITS (COORD_BITS),
        .JOB_W      (JOB_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_win   (i_win),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    wmds_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (head_job)
    );

    wmds_back #(
        .COORD_BITS (COORD_BITS),
        .JOB_W      (JOB_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_strip (o_strip)
    );

endmodule

`default_nettype wire

### tb/window_move_difference_strips_core_tb.sv
// Self-checking testbench: drives window moves, checks strips against predicted or typed ones.
`default_nettype none

module window_move_difference_strips_core_tb;

    localparam int COORD_BITS = 16;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] top;
        logic        [COORD_BITS-2:0] width;
        logic        [COORD_BITS-2:0] height;
    } t_window;

    typedef struct packed {
        logic    kind;
        t_window box;
        logic    last;
    } t_strip;

    typedef struct packed {
        t_window    win;
        logic       typed;
        logic [1:0] typed_count;
        t_strip     s0;
        t_strip     s1;
    } t_move_row;

    logic i_clk;
    logic i_rst_n;

    wmds_win_if   #(.COORD_BITS(COORD_BITS)) win_if ();
    wmds_strip_if #(.COORD_BITS(COORD_BITS)) strip_if ();

    window_move_difference_strips_core #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_win  (win_if),
        .o_strip(strip_if)
    );

    t_window   window_state;
    t_strip    move_strips[$];
    t_strip    expected_strips[$];
    t_move_row directed_moves[$];
    int        mismatch_count = 0;
    int        send_idle_pct = 10;
    int        take_idle_pct = 10;
    bit        hold_pending = 1'b0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_window win(input int l, input int t, input int w, input int h);
        t_window r;
        r.left   = l[COORD_BITS-1:0];
        r.top    = t[COORD_BITS-1:0];
        r.width  = w[COORD_BITS-2:0];
        r.height = h[COORD_BITS-2:0];
        return r;
    endfunction

    function automatic t_move_row row(input t_window w, input bit typed = 1'b0,
                                      input int count = 0, input t_strip s0 = '0,
                                      input t_strip s1 = '0);
        t_move_row r;
        r.win         = w;
        r.typed       = typed;
        r.typed_count = count[1:0];
        r.s0          = s0;
        r.s1          = s1;
        return r;
    endfunction

    function automatic void add_strip(input logic kind, input longint l, input longint t,
                                      input longint w, input longint h);
        t_strip s;
        if (w <= 0 || h <= 0) return;
        s.kind       = kind;
        s.box.left   = l[COORD_BITS-1:0];
        s.box.top    = t[COORD_BITS-1:0];
        s.box.width  = w[COORD_BITS-2:0];
        s.box.height = h[COORD_BITS-2:0];
        s.last       = 1'b0;
        move_strips.push_back(s);
    endfunction

    // Computes the strips of one move and then takes the new window as the stored one.
    function automatic void predict_move(input t_window nw);
        longint ol, ot, ow, oh, ox2, oy2;
        longint nl, nt, nwd, nht, nx2, ny2;
        longint cs, ce, rs, re;
        bit     overlap;
        ol  = $signed(window_state.left);
        ot  = $signed(window_state.top);
        ow  = longint'(window_state.width);
        oh  = longint'(window_state.height);
        nl  = $signed(nw.left);
        nt  = $signed(nw.top);
        nwd = longint'(nw.width);
        nht = longint'(nw.height);
        ox2 = ol + ow;
        oy2 = ot + oh;
        nx2 = nl + nwd;
        ny2 = nt + nht;
        cs  = (ol > nl) ? ol : nl;
        ce  = (ox2 < nx2) ? ox2 : nx2;
        rs  = (ot > nt) ? ot : nt;
        re  = (oy2 < ny2) ? oy2 : ny2;
        overlap = ow > 0 && oh > 0 && nwd > 0 && nht > 0 && cs < ce && rs < re;
        move_strips.delete();
        if (!overlap) begin
            add_strip(wmds_pkg::KIND_REMOVE, ol, ot, ow, oh);
            add_strip(wmds_pkg::KIND_ADD, nl, nt, nwd, nht);
        end else begin
            if (ot < nt)   add_strip(wmds_pkg::KIND_REMOVE, ol, ot, ow, nt - ot);
            if (ny2 < oy2) add_strip(wmds_pkg::KIND_REMOVE, ol, ny2, ow, oy2 - ny2);
            if (ol < nl)   add_strip(wmds_pkg::KIND_REMOVE, ol, rs, nl - ol, re - rs);
            if (nx2 < ox2) add_strip(wmds_pkg::KIND_REMOVE, nx2, rs, ox2 - nx2, re - rs);
            if (nt < ot)   add_strip(wmds_pkg::KIND_ADD, nl, nt, nwd, ot - nt);
            if (oy2 < ny2) add_strip(wmds_pkg::KIND_ADD, nl, oy2, nwd, ny2 - oy2);
            if (nl < ol)   add_strip(wmds_pkg::KIND_ADD, nl, rs, ol - nl, re - rs);
            if (ox2 < nx2) add_strip(wmds_pkg::KIND_ADD, ox2, rs, nx2 - ox2, re - rs);
        end
        if (move_strips.size() != 0) move_strips[move_strips.size()-1].last = 1'b1;
        window_state = nw;
    endfunction

    function automatic t_window random_window();
        t_window w;
        int      pick;
        int      nsize;
        w    = window_state;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            w.left   = 16'($urandom);
            w.top    = 16'($urandom);
            w.width  = 15'($urandom);
            w.height = 15'($urandom);
        end else if (pick < 4) begin
            w = window_state;
        end else if (pick < 6) begin
            w.left   = 16'($urandom_range(0, 63)) - 16'd32;
            w.top    = 16'($urandom_range(0, 63)) - 16'd32;
            w.width  = $urandom_range(0, 1) ? 15'd0 : 15'($urandom_range(0, 9));
            w.height = (w.width == 15'd0) ? 15'($urandom_range(0, 9)) : 15'd0;
        end else if (pick < 7) begin
            w.left   = $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 15))
                                            : 16'h8000 + 16'($urandom_range(0, 15));
            w.top    = $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 15))
                                            : 16'h8000 + 16'($urandom_range(0, 15));
            w.width  = $urandom_range(0, 1) ? 15'h7fff - 15'($urandom_range(0, 31))
                                            : 15'($urandom_range(1, 31));
            w.height = $urandom_range(0, 1) ? 15'h7fff - 15'($urandom_range(0, 31))
                                            : 15'($urandom_range(1, 31));
        end else if (window_state.width == 15'd0 || window_state.height == 15'd0 ||
                     window_state.width > 15'd64 || window_state.height > 15'd64) begin
            w.left   = 16'($urandom_range(0, 40)) - 16'd20;
            w.top    = 16'($urandom_range(0, 40)) - 16'd20;
            w.width  = 15'($urandom_range(1, 12));
            w.height = 15'($urandom_range(1, 12));
        end else begin
            w.left = window_state.left + 16'($urandom_range(0, 8)) - 16'd4;
            w.top  = window_state.top + 16'($urandom_range(0, 8)) - 16'd4;
            nsize  = int'(window_state.width) + int'($urandom_range(0, 4)) - 2;
            w.width = 15'((nsize < 1) ? 1 : nsize);
            nsize  = int'(window_state.height) + int'($urandom_range(0, 4)) - 2;
            w.height = 15'((nsize < 1) ? 1 : nsize);
        end
        return w;
    endfunction

    task automatic send_window(input t_window w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            win_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        win_if.valid      <= 1'b1;
        win_if.new_left   <= w.left;
        win_if.new_top    <= w.top;
        win_if.new_width  <= w.width;
        win_if.new_height <= w.height;
        @(posedge i_clk);
        while (!win_if.ready) @(posedge i_clk);
    endtask

    task automatic report_field(input string name, input longint expv, input longint actv);
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expv, actv);
        mismatch_count++;
    endtask

    initial begin
        int remaining;
        strip_if.ready <= 1'b0;
        remaining = 0;
        forever begin
            @(posedge i_clk);
            if (remaining > 0) begin
                strip_if.ready <= 1'b0;
                remaining--;
            end else if (hold_pending) begin
                hold_pending = 1'b0;
                remaining = 60;
                strip_if.ready <= 1'b0;
            end else begin
                strip_if.ready <= ($urandom_range(0, 99) >= take_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_strip got;
        t_strip exp;
        if (i_rst_n && strip_if.valid && strip_if.ready) begin
            got.kind       = strip_if.strip_kind;
            got.box.left   = strip_if.strip_left;
            got.box.top    = strip_if.strip_top;
            got.box.width  = strip_if.strip_width;
            got.box.height = strip_if.strip_height;
            got.last       = strip_if.strip_last;
            if (expected_strips.size() == 0) begin
                $display("%0t: unexpected strip: expected none, actual %p", $time, got);
                mismatch_count++;
            end else begin
                exp = expected_strips.pop_front();
                if (got.kind !== exp.kind)
                    report_field("strip_kind", exp.kind, got.kind);
                if (got.box.left !== exp.box.left)
                    report_field("strip_left", $signed(exp.box.left), $signed(got.box.left));
                if (got.box.top !== exp.box.top)
                    report_field("strip_top", $signed(exp.box.top), $signed(got.box.top));
                if (got.box.width !== exp.box.width)
                    report_field("strip_width", exp.box.width, got.box.width);
                if (got.box.height !== exp.box.height)
                    report_field("strip_height", exp.box.height, got.box.height);
                if (got.last !== exp.last)
                    report_field("strip_last", exp.last, got.last);
            end
        end
    end

    initial begin
        #3000000;
        $display("window_move_difference_strips_core test failed");
        $finish;
    end

    initial begin
        t_window w;
        i_rst_n           <= 1'b0;
        win_if.valid      <= 1'b0;
        win_if.new_left   <= '0;
        win_if.new_top    <= '0;
        win_if.new_width  <= '0;
        win_if.new_height <= '0;
        window_state = '0;

        directed_moves.push_back(row(win(0, 0, 0, 0), 1'b1, 0));
        directed_moves.push_back(row(win(0, 0, 4, 3), 1'b1, 1,
                                     t_strip'{wmds_pkg::KIND_ADD, win(0, 0, 4, 3), 1'b1}));
        directed_moves.push_back(row(win(0, 0, 4, 3), 1'b1, 0));
        directed_moves.push_back(row(win(1, 1, 4, 3)));
        directed_moves.push_back(row(win(5, 1, 2, 3), 1'b1, 2,
                                     t_strip'{wmds_pkg::KIND_REMOVE, win(1, 1, 4, 3), 1'b0},
                                     t_strip'{wmds_pkg::KIND_ADD, win(5, 1, 2, 3), 1'b1}));
        directed_moves.push_back(row(win(5, 4, 2, 3)));
        directed_moves.push_back(row(win(4, 3, 4, 4)));
        directed_moves.push_back(row(win(5, 4, 1, 1)));
        directed_moves.push_back(row(win(-10, -10, 30, 30)));
        directed_moves.push_back(row(win(3, 3, 0, 5), 1'b1, 1,
                                     t_strip'{wmds_pkg::KIND_REMOVE,
                                              win(-10, -10, 30, 30), 1'b1}));
        directed_moves.push_back(row(win(3, 3, 5, 0), 1'b1, 0));
        directed_moves.push_back(row(win(-32768, -32768, 32767, 32767), 1'b1, 1,
                                     t_strip'{wmds_pkg::KIND_ADD,
                                              win(-32768, -32768, 32767, 32767), 1'b1}));
        directed_moves.push_back(row(win(32767, 32767, 32767, 32767), 1'b1, 2,
                                     t_strip'{wmds_pkg::KIND_REMOVE,
                                              win(-32768, -32768, 32767, 32767), 1'b0},
                                     t_strip'{wmds_pkg::KIND_ADD,
                                              win(32767, 32767, 32767, 32767), 1'b1}));
        directed_moves.push_back(row(win(32767, 32767, 1, 1)));
        directed_moves.push_back(row(win(-32768, 32767, 32767, 1)));
        directed_moves.push_back(row(win(-1, 32767, 2, 1)));
        directed_moves.push_back(row(win(0, 0, 10, 10)));
        directed_moves.push_back(row(win(2, -3, 4, 20)));
        directed_moves.push_back(row(win(-5, 2, 20, 3)));
        directed_moves.push_back(row(win(-5, 2, 20, 3), 1'b1, 0));
        directed_moves.push_back(row(win(-6, 1, 22, 5)));
        directed_moves.push_back(row(win(0, 0, 0, 0), 1'b1, 1,
                                     t_strip'{wmds_pkg::KIND_REMOVE,
                                              win(-6, 1, 22, 5), 1'b1}));
        directed_moves.push_back(row(win(21845, -21846, 10922, 21845)));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_moves[i]) begin
            predict_move(directed_moves[i].win);
            if (directed_moves[i].typed) begin
                if (directed_moves[i].typed_count > 0)
                    expected_strips.push_back(directed_moves[i].s0);
                if (directed_moves[i].typed_count > 1)
                    expected_strips.push_back(directed_moves[i].s1);
            end else begin
                foreach (move_strips[j]) expected_strips.push_back(move_strips[j]);
            end
            send_window(directed_moves[i].win);
        end

        for (int n = 0; n < 350; n++) begin
            if (n == 150) hold_pending = 1'b1;
            if (n == 250) begin
                send_idle_pct = 0;
                take_idle_pct = 0;
            end
            if (n == 320) begin
                send_idle_pct = 10;
                take_idle_pct = 10;
            end
            w = random_window();
            predict_move(w);
            foreach (move_strips[j]) expected_strips.push_back(move_strips[j]);
            send_window(w);
        end
        win_if.valid <= 1'b0;

        while (expected_strips.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("window_move_difference_strips_core test passed");
        end else begin
            $display("window_move_difference_strips_core test failed");
        end
        $finish;
    end
endmodule

`default_nettype wire

### sim.f
sv/wmds_pkg.sv
sv/wmds_win_if.sv
sv/wmds_strip_if.sv
sv/wmds_front.sv
sv/wmds_queue.sv
sv/wmds_back.sv
sv/window_move_difference_strips_core.sv
tb/window_move_difference_strips_core_tb.sv
